// ----- hw/rtl/pts_pkg.sv -----
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants for the priority task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

   localparam int MAX_TASKS_DEF = 8;

   localparam logic [6:0] CREDIT_RELOAD = 7'd100;

   // task states
   localparam logic [1:0] TS_READY    = 2'd0;
   localparam logic [1:0] TS_RUNNING  = 2'd1;
   localparam logic [1:0] TS_SLEEPING = 2'd2;

   // item operations
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_ADD   = 2'd1;
   localparam logic [1:0] OP_SLEEP = 2'd2;

   // datapath actions
   localparam logic [2:0] ACT_NONE    = 3'd0;
   localparam logic [2:0] ACT_CAPTURE = 3'd1;
   localparam logic [2:0] ACT_TICK    = 3'd2;
   localparam logic [2:0] ACT_ADD     = 3'd3;
   localparam logic [2:0] ACT_MARK    = 3'd4;
   localparam logic [2:0] ACT_SCAN    = 3'd5;
   localparam logic [2:0] ACT_RUN     = 3'd6;
   localparam logic [2:0] ACT_RSP     = 3'd7;

   // table index control
   localparam logic [2:0] IDX_HOLD = 3'd0;
   localparam logic [2:0] IDX_ZERO = 3'd1;
   localparam logic [2:0] IDX_INC  = 3'd2;
   localparam logic [2:0] IDX_OLD  = 3'd3;
   localparam logic [2:0] IDX_BEST = 3'd4;
   localparam logic [2:0] IDX_CNT  = 3'd5;

   typedef struct packed {
      logic [2:0] act;
      logic [2:0] idx;
   } cmd_type;

   typedef struct packed {
      logic cnt_zero;
      logic idx_last;
   } status_type;

endpackage

// ----- hw/rtl/pts_ctrl.sv -----
// ----------------------------------------------------------------------------
// pts_ctrl
// Sequencer for the scheduler: steps the table walk for each item and
// runs the request and response handshakes.
// ----------------------------------------------------------------------------
module pts_ctrl
   import pts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_op,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd,
   input  status_type status
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_TICK = 3'd1;
   localparam logic [2:0] S_ADD  = 3'd2;
   localparam logic [2:0] S_MARK = 3'd3;
   localparam logic [2:0] S_SCAN = 3'd4;
   localparam logic [2:0] S_RUN  = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cmd.act      = ACT_NONE;
      cmd.idx      = IDX_HOLD;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.act = ACT_CAPTURE;
               case (req_op)
                  OP_TICK: begin
                     cmd.idx  = IDX_ZERO;
                     state_in = status.cnt_zero ? S_DONE : S_TICK;
                  end
                  OP_ADD: begin
                     cmd.idx  = IDX_CNT;
                     state_in = S_ADD;
                  end
                  OP_SLEEP: begin
                     cmd.idx  = IDX_OLD;
                     state_in = status.cnt_zero ? S_DONE : S_MARK;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_TICK: begin
            cmd.act = ACT_TICK;
            cmd.idx = IDX_INC;
            if (status.idx_last) begin
               state_in = S_DONE;
            end
         end
         S_ADD: begin
            cmd.act  = ACT_ADD;
            state_in = S_DONE;
         end
         S_MARK: begin
            cmd.act  = ACT_MARK;
            cmd.idx  = IDX_ZERO;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.act = ACT_SCAN;
            if (status.idx_last) begin
               cmd.idx  = IDX_BEST;
               state_in = S_RUN;
            end else begin
               cmd.idx = IDX_INC;
            end
         end
         S_RUN: begin
            cmd.act  = ACT_RUN;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.act      = ACT_RSP;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- hw/rtl/pts_dp.sv -----
// ----------------------------------------------------------------------------
// pts_dp
// Task table and scheduler datapath: one table entry is read and written
// per cycle at the walk index.
// ----------------------------------------------------------------------------
module pts_dp
   import pts_pkg::*;
#(
   parameter int MAX_TASKS = MAX_TASKS_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_priority_req,
   input  logic [15:0] req_sleep_ticks,
   input  cmd_type     cmd,
   output status_type  status,
   output logic [2:0]  rsp_current_task,
   output logic [3:0]  rsp_task_count,
   output logic        rsp_add_failed
);

   localparam int IW = $clog2(MAX_TASKS);
   localparam int CW = $clog2(MAX_TASKS + 1);

   logic [1:0]    state_ff [MAX_TASKS];
   logic [7:0]    prio_ff  [MAX_TASKS];
   logic [15:0]   sleep_ff [MAX_TASKS];
   logic [6:0]    cred_ff  [MAX_TASKS];

   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] running_ff, running_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [IW-1:0] best_ff, best_in;
   logic [7:0]    best_pri_ff, best_pri_in;
   logic [6:0]    best_cred_ff, best_cred_in;
   logic [7:0]    pri_ff, pri_in;
   logic [15:0]   ticks_ff, ticks_in;
   logic          failed_ff, failed_in;

   logic [2:0]    out_task_ff, out_task_in;
   logic [3:0]    out_count_ff, out_count_in;
   logic          out_failed_ff, out_failed_in;

   logic [1:0]    cur_st, st_in;
   logic [7:0]    cur_pri, ent_pri_in;
   logic [15:0]   cur_sl, sl_in;
   logic [6:0]    cur_cr, cr_in;
   logic          wr_en;
   logic          full;
   logic [31:0]   run_wide;
   logic [31:0]   cnt_wide;

   assign cur_st  = state_ff[idx_ff];
   assign cur_pri = prio_ff[idx_ff];
   assign cur_sl  = sleep_ff[idx_ff];
   assign cur_cr  = cred_ff[idx_ff];

   assign full            = (count_ff == CW'(MAX_TASKS));
   assign status.cnt_zero = (count_ff == '0);
   assign status.idx_last = ((CW'(idx_ff) + CW'(1)) == count_ff);

   assign run_wide = 32'(running_ff);
   assign cnt_wide = 32'(count_ff);

   // index sequencing
   always_comb begin
      case (cmd.idx)
         IDX_ZERO: idx_in = '0;
         IDX_INC:  idx_in = idx_ff + IW'(1);
         IDX_OLD:  idx_in = running_ff;
         IDX_BEST: idx_in = best_in;
         IDX_CNT:  idx_in = count_ff[IW-1:0];
         default:  idx_in = idx_ff;
      endcase
   end

   // entry update and scalar state
   always_comb begin
      st_in         = cur_st;
      ent_pri_in    = cur_pri;
      sl_in         = cur_sl;
      cr_in         = cur_cr;
      wr_en         = 1'b0;
      count_in      = count_ff;
      running_in    = running_ff;
      best_in       = best_ff;
      best_pri_in   = best_pri_ff;
      best_cred_in  = best_cred_ff;
      pri_in        = pri_ff;
      ticks_in      = ticks_ff;
      failed_in     = failed_ff;
      out_task_in   = out_task_ff;
      out_count_in  = out_count_ff;
      out_failed_in = out_failed_ff;
      case (cmd.act)
         ACT_CAPTURE: begin
            pri_in    = req_priority_req;
            ticks_in  = req_sleep_ticks;
            failed_in = 1'b0;
         end
         ACT_TICK: begin
            wr_en = 1'b1;
            if (cur_sl != 16'd0) begin
               sl_in = cur_sl - 16'd1;
            end else if (cur_st == TS_SLEEPING) begin
               st_in = TS_READY;
            end else if (cur_st == TS_RUNNING && cur_cr != 7'd0) begin
               cr_in = cur_cr - 7'd1;
            end
         end
         ACT_ADD: begin
            if (full) begin
               failed_in = 1'b1;
            end else begin
               wr_en      = 1'b1;
               st_in      = TS_READY;
               ent_pri_in = pri_ff;
               sl_in      = 16'd0;
               cr_in      = 7'd0;
               count_in   = count_ff + CW'(1);
            end
         end
         ACT_MARK: begin
            wr_en = 1'b1;
            st_in = TS_SLEEPING;
            sl_in = ticks_ff;
            if (cur_cr == 7'd0 && idx_ff != '0) begin
               cr_in = CREDIT_RELOAD;
            end
         end
         ACT_SCAN: begin
            if (idx_ff == '0) begin
               best_in      = '0;
               best_pri_in  = (cur_st == TS_READY) ? cur_pri : 8'd0;
               best_cred_in = cur_cr;
            end else if (cur_st == TS_READY) begin
               if (cur_pri > best_pri_ff) begin
                  best_in      = idx_ff;
                  best_pri_in  = cur_pri;
                  best_cred_in = cur_cr;
               end else if (cur_pri == best_pri_ff && cur_cr > best_cred_ff) begin
                  best_in      = idx_ff;
                  best_cred_in = cur_cr;
               end
            end
         end
         ACT_RUN: begin
            wr_en      = 1'b1;
            st_in      = TS_RUNNING;
            running_in = idx_ff;
         end
         ACT_RSP: begin
            out_task_in   = run_wide[2:0];
            out_count_in  = cnt_wide[3:0];
            out_failed_in = failed_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TASKS; i++) begin
            state_ff[i] <= TS_READY;
            prio_ff[i]  <= 8'd0;
            sleep_ff[i] <= 16'd0;
            cred_ff[i]  <= 7'd0;
         end
         count_ff   <= '0;
         running_ff <= '0;
         idx_ff     <= '0;
      end else begin
         if (wr_en) begin
            state_ff[idx_ff] <= st_in;
            prio_ff[idx_ff]  <= ent_pri_in;
            sleep_ff[idx_ff] <= sl_in;
            cred_ff[idx_ff]  <= cr_in;
         end
         count_ff   <= count_in;
         running_ff <= running_in;
         idx_ff     <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff       <= best_in;
      best_pri_ff   <= best_pri_in;
      best_cred_ff  <= best_cred_in;
      pri_ff        <= pri_in;
      ticks_ff      <= ticks_in;
      failed_ff     <= failed_in;
      out_task_ff   <= out_task_in;
      out_count_ff  <= out_count_in;
      out_failed_ff <= out_failed_in;
   end

   assign rsp_current_task = out_task_ff;
   assign rsp_task_count   = out_count_ff;
   assign rsp_add_failed   = out_failed_ff;

endmodule

// ----- hw/rtl/priority_task_scheduler.sv -----
// ----------------------------------------------------------------------------
// priority_task_scheduler
// Priority task scheduler over a table of up to MAX_TASKS tasks.
// ----------------------------------------------------------------------------
// Each req item carries an op: tick, add task (req_priority_req) or sleep
// the current task for req_sleep_ticks ticks and pick the next one. Every
// item returns one rsp item: current task, task count and the add failure
// flag. Both channels are valid/ready.
// One item is worked at a time; the table is walked one entry per cycle.
// An add writes one new entry unless the table is full; a tick walks every
//   entry; a sleep marks the current task, scans every entry and runs the best,
//   while an empty-table tick or sleep and an unused op go straight to rsp.
// A new item is taken once the previous result sits in the rsp register,
// so a stalled receiver holds off the next item only after the current one
// finishes. Synchronous reset empties the table and makes task 0 current.
// ----------------------------------------------------------------------------
module priority_task_scheduler
   import pts_pkg::*;
#(
   parameter int MAX_TASKS = MAX_TASKS_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_priority_req,
   input  logic [15:0] req_sleep_ticks,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_current_task,
   output logic [3:0]  rsp_task_count,
   output logic        rsp_add_failed
);

   cmd_type    cmd;
   status_type status;

   pts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   pts_dp #(
      .MAX_TASKS (MAX_TASKS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_priority_req (req_priority_req),
      .req_sleep_ticks  (req_sleep_ticks),
      .cmd              (cmd),
      .status           (status),
      .rsp_current_task (rsp_current_task),
      .rsp_task_count   (rsp_task_count),
      .rsp_add_failed   (rsp_add_failed)
   );

endmodule

// ----- hw/rtl/pts_chk.sv -----
// ----------------------------------------------------------------------------
// pts_chk
// Port-level checks for the priority task scheduler.
// ----------------------------------------------------------------------------
module pts_chk
   import pts_pkg::*;
#(
   parameter int MAX_TASKS = MAX_TASKS_DEF
)
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_current_task,
   input logic [3:0]  rsp_task_count,
   input logic        rsp_add_failed
);

   logic [3:0] last_cnt_ff, last_cnt_in;

   assign last_cnt_in = (rsp_valid && rsp_ready) ? rsp_task_count : last_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_cnt_ff <= 4'd0;
      end else begin
         last_cnt_ff <= last_cnt_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_current_task)
         && $stable(rsp_task_count) && $stable(rsp_add_failed))
      else $error("rsp item changed while stalled");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |-> rsp_task_count == last_cnt_ff
         || rsp_task_count == last_cnt_ff + 4'd1)
      else $error("task count moved by more than one add");

   a_fail_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_add_failed |-> rsp_task_count == 4'(MAX_TASKS))
      else $error("add failed on a table that is not full");

   a_empty_task0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_task_count == 4'd0 && MAX_TASKS <= 8 |-> rsp_current_task == 3'd0)
      else $error("empty table with nonzero current task");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid straight after reset");

endmodule

bind priority_task_scheduler pts_chk #(.MAX_TASKS(MAX_TASKS)) u_pts_chk (.*);
